// File: rtl/far_pkg.sv
// Package for the fraction arithmetic block: operation and status codes,
// beat types and controller command/status structs. No dependencies.
`default_nettype none
package far_pkg;
    localparam int unsigned InWidthDef = 32;
    localparam int unsigned MagW = 64;
    localparam int unsigned DenW = 62;
    localparam int unsigned CntW = 7;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] num_a;
        logic [31:0] den_a;
        logic [31:0] num_b;
        logic [31:0] den_b;
    } t_in;

    typedef struct packed {
        logic [63:0] res_num;
        logic [61:0] res_den;
        logic [1:0]  status;
    } t_out;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic sum;
        logic gcd_step;
        logic div_start;
        logic div_step;
    } t_cmd;

    typedef struct packed {
        logic early;
        logic div_done;
        logic y_zero;
    } t_status;
endpackage
`default_nettype wire

// File: rtl/far_if.sv
// Valid/ready channel interface carrying one payload beat.
// Depends on nothing; payload type given as a parameter.
`default_nettype none
interface far_if #(parameter type T = logic) (input wire logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/far_ctrl.sv
// Controller for the fraction arithmetic block: sequences products,
// Euclidean GCD and the two exact divisions. Depends on far_pkg.
`default_nettype none
module far_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    input  wire far_pkg::t_status   i_status,
    output far_pkg::t_cmd           o_cmd
);
    import far_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_GCD  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                if (i_status.early) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.mul1 = 1'b1;
                    n_state = S_MUL2;
                end
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = S_GCD;
            end
            S_GCD: begin
                if (i_status.y_zero) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/far_dp.sv
// Datapath for the fraction arithmetic block: operand decode, products,
// signed sum, bit-serial modulo for GCD and shared bit-serial division.
// Depends on far_pkg.
`default_nettype none
module far_dp #(
    parameter int unsigned IN_WIDTH = far_pkg::InWidthDef
) (
    input  wire logic                    i_clk,
    input  wire far_pkg::t_cmd           i_cmd,
    input  wire logic [1:0]              i_op,
    input  wire logic [IN_WIDTH-1:0]     i_num_a,
    input  wire logic [IN_WIDTH-1:0]     i_den_a,
    input  wire logic [IN_WIDTH-1:0]     i_num_b,
    input  wire logic [IN_WIDTH-1:0]     i_den_b,
    output far_pkg::t_status             o_status,
    output logic signed [63:0]           o_res_num,
    output logic [61:0]                  o_res_den,
    output logic [1:0]                   o_res_status
);
    import far_pkg::*;

    logic [1:0]          r_op;
    logic [IN_WIDTH-1:0] r_ma, r_mb, r_mc, r_md;
    logic                r_sa, r_sb, r_sc, r_sd;
    logic [MagW-1:0]     r_p1, r_p2, r_den;
    logic                r_p1n, r_p2n, r_dn;
    logic [MagW-1:0]     r_num;
    logic                r_neg;
    logic [MagW-1:0]     r_x, r_y, r_rem, r_q;
    logic [CntW-1:0]     r_cnt;
    logic                r_mod_busy;
    logic                r_phase;
    logic [MagW-1:0]     r_nq;
    logic [MagW-1:0]     r_dd;
    logic                r_dd_ok;
    logic [1:0]          r_stat;

    function automatic logic [IN_WIDTH-1:0] f_mag(input logic [IN_WIDTH-1:0] v);
        return v[IN_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    logic [MagW-1:0] w_prod;
    logic [IN_WIDTH-1:0] w_m1, w_m2;
    logic [MagW:0] w_sh;
    logic          w_ge;
    logic [MagW-1:0] w_rnext, w_qnext;
    logic [MagW-1:0] w_sum_mag;
    logic w_sum_neg;

    always_comb begin
        w_m1 = i_cmd.mul1 ? r_ma : r_mb;
        w_m2 = i_cmd.mul1 ? ((r_op == OP_MUL) ? r_mc : r_md)
                          : ((r_op == OP_DIV) ? r_mc : r_md);
        w_prod = MagW'(w_m1) * MagW'(w_m2);
    end

    always_comb begin
        logic p2n;
        p2n = (r_op == OP_SUB) ? ~r_p2n : r_p2n;
        if (r_p1n == p2n) begin
            w_sum_mag = r_p1 + r_p2;
            w_sum_neg = r_p1n;
        end else if (r_p1 >= r_p2) begin
            w_sum_mag = r_p1 - r_p2;
            w_sum_neg = r_p1n;
        end else begin
            w_sum_mag = r_p2 - r_p1;
            w_sum_neg = p2n;
        end
    end

    // One restoring division step on r_rem/r_q by divisor r_y.
    assign w_sh    = {r_rem, r_q[MagW-1]};
    assign w_ge    = (w_sh >= {1'b0, r_y});
    assign w_rnext = w_ge ? MagW'(w_sh - {1'b0, r_y}) : w_sh[MagW-1:0];
    assign w_qnext = {r_q[MagW-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_ma  <= f_mag(i_num_a);
            r_mb  <= f_mag(i_den_a);
            r_mc  <= f_mag(i_num_b);
            r_md  <= f_mag(i_den_b);
            r_sa  <= i_num_a[IN_WIDTH-1];
            r_sb  <= i_den_a[IN_WIDTH-1];
            r_sc  <= i_num_b[IN_WIDTH-1];
            r_sd  <= i_den_b[IN_WIDTH-1];
            if (i_den_a == '0 || i_den_b == '0) begin
                r_stat <= ST_ZDEN;
            end else if (i_op == OP_DIV && i_num_b == '0) begin
                r_stat <= ST_DIVZ;
            end else begin
                r_stat <= ST_OK;
            end
        end
        if (i_cmd.mul1) begin
            r_p1  <= w_prod;
            r_p1n <= (r_sa ^ ((r_op == OP_MUL) ? r_sc : r_sd)) && (w_prod != '0);
        end
        if (i_cmd.mul2) begin
            if (r_op == OP_MUL) begin
                r_p2 <= '0;
                r_p2n <= 1'b0;
            end else begin
                r_p2  <= MagW'(r_mc) * MagW'(r_mb);
                r_p2n <= (r_sc ^ r_sb) && (r_mc != '0);
            end
            r_den <= w_prod;
            r_dn  <= r_sb ^ ((r_op == OP_DIV) ? r_sc : r_sd);
        end
        if (i_cmd.sum) begin
            if (r_op == OP_ADD || r_op == OP_SUB) begin
                r_num <= w_sum_mag;
                r_neg <= (w_sum_neg ^ r_dn) && (w_sum_mag != '0);
                r_x   <= w_sum_mag;
            end else begin
                r_num <= r_p1;
                r_neg <= (r_p1n ^ r_dn) && (r_p1 != '0);
                r_x   <= r_p1;
            end
            r_y        <= r_den;
            r_mod_busy <= 1'b0;
        end
        if (i_cmd.gcd_step) begin
            if (!r_mod_busy) begin
                r_rem      <= '0;
                r_q        <= r_x;
                r_cnt      <= '0;
                r_mod_busy <= 1'b1;
            end else begin
                r_rem <= w_rnext;
                r_q   <= {r_q[MagW-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(MagW-1)) begin
                    r_x        <= r_y;
                    r_y        <= w_rnext;
                    r_mod_busy <= 1'b0;
                end
            end
        end
        if (i_cmd.div_start) begin
            r_y     <= r_x;
            r_rem   <= '0;
            r_q     <= r_num;
            r_cnt   <= '0;
            r_phase <= 1'b0;
            r_dd_ok <= 1'b0;
        end
        if (i_cmd.div_step) begin
            if (r_cnt == CntW'(MagW-1)) begin
                r_cnt <= '0;
                r_rem <= '0;
                if (!r_phase) begin
                    r_nq    <= w_qnext;
                    r_q     <= r_den;
                    r_phase <= 1'b1;
                end else begin
                    r_dd    <= w_qnext;
                    r_phase <= 1'b0;
                    r_dd_ok <= 1'b1;
                end
            end else begin
                r_rem <= w_rnext;
                r_q   <= w_qnext;
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_status.early    = (r_stat != ST_OK);
    assign o_status.y_zero   = (r_y == '0) && !r_mod_busy;
    assign o_status.div_done = r_dd_ok;

    always_comb begin
        if (r_stat != ST_OK) begin
            o_res_num = 64'sd0;
            o_res_den = 62'd1;
        end else begin
            o_res_num = r_neg ? $signed(~r_nq + 1'b1) : $signed(r_nq);
            o_res_den = r_dd[DenW-1:0];
        end
        o_res_status = r_stat;
    end
endmodule
`default_nettype wire

// File: rtl/fraction_arithmetic_reduce.sv
// Top level of the fraction arithmetic block: rational add, subtract,
// multiply and divide with reduction to lowest terms.
// Depends on far_pkg, far_if, far_ctrl and far_dp.
//
// One item enters on the input channel (cmd and four signed operand
// parts) and one result leaves on the output channel (reduced numerator,
// positive denominator, status). One item is worked on at a time; the
// input takes a new beat in the cycle after the previous result has been
// taken. A bad denominator or a divide by zero sends the controller from
// the first product state straight to the output state, where the result
// can be taken. Otherwise the products and sum are followed by k
// Euclidean modulo steps, where k is the number of modulo steps (up to
// about 90), in the bit-serial remainder unit, then the start of the
// divisions and the two exact divisions in the same unit, and then the
// result can be taken. While the receiver stalls the result holds on
// the output. Reset returns the controller to idle; nothing is cleared.
`default_nettype none
module fraction_arithmetic_reduce #(
    parameter int unsigned IN_WIDTH = far_pkg::InWidthDef
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    far_if.sink      i_in,
    far_if.source    o_out
);
    import far_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic signed [63:0] w_num;
    logic [61:0] w_den;
    logic [1:0]  w_st;

    far_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    far_dp #(.IN_WIDTH(IN_WIDTH)) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .i_op         (i_in.data.cmd),
        .i_num_a      (i_in.data.num_a[IN_WIDTH-1:0]),
        .i_den_a      (i_in.data.den_a[IN_WIDTH-1:0]),
        .i_num_b      (i_in.data.num_b[IN_WIDTH-1:0]),
        .i_den_b      (i_in.data.den_b[IN_WIDTH-1:0]),
        .o_status     (w_status),
        .o_res_num    (w_num),
        .o_res_den    (w_den),
        .o_res_status (w_st)
    );

    assign o_out.data.res_num = w_num;
    assign o_out.data.res_den = w_den;
    assign o_out.data.status  = w_st;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.data.res_num))
        else $error("result changed while stalled");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while result pending");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.data.status <= ST_DIVZ)
        else $error("unknown status on output");
endmodule
`default_nettype wire
